// ===== rtl/core/epoch_seconds_to_calendar_defines.svh =====
// Assertion macros for the epoch to calendar converter.
// Define NO_ASSERTIONS to compile the assertions out.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at each rising clock edge
`define ESC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("esc assertion failed");

// Next-cycle implication, checked at each rising clock edge
`define ESC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("esc assertion failed");

`else

`define ESC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ESC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/esc_pkg.sv =====
package esc_pkg;

   // Sequencer phases
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_SEC,
      ST_DIV_MIN,
      ST_DIV_HOUR,
      ST_DIV_WDAY,
      ST_YEAR_SCAN,
      ST_MONTH_SCAN,
      ST_FINISH
   } esc_state_type;

   // Configuration register indexes
   localparam logic CsrTimezone   = 1'b0;
   localparam logic CsrSummertime = 1'b1;

   // Reset values of the configuration registers
   localparam logic signed [4:0] TimezoneReset   = 5'sd1;
   localparam logic              SummertimeReset = 1'b1;

   // Shared subtractor width
   localparam int SubWidth = 17;

   // Dividend register width
   localparam int DivWidth = 32;

   // Reciprocals: floor(x / d) = (x * Recip) >> Shift
   localparam logic [31:0] RecipSixty = 32'h8888_8889;  // any 32-bit x
   localparam int          ShiftSixty = 37;
   localparam logic [31:0] RecipDay   = 32'hAAAA_AAAB;  // any 32-bit x
   localparam int          ShiftDay   = 36;
   localparam logic [31:0] RecipWeek  = 32'h9249_2493;  // x below 3.4e9
   localparam int          ShiftWeek  = 34;

   localparam logic [5:0] SecPerMin  = 6'd60;
   localparam logic [5:0] MinPerHour = 6'd60;
   localparam logic [5:0] HourPerDay = 6'd24;
   localparam logic [5:0] DaysPerWk  = 6'd7;

   // 1970-01-01 was a Thursday: weekday index offset
   localparam logic [15:0] WdayBias = 16'd4;

   // Calendar constants
   localparam int          EpochYear   = 1970;
   localparam logic [7:0]  YoffY2100   = 8'(2100 - EpochYear);
   localparam logic [7:0]  YoffY2200   = 8'(2200 - EpochYear);
   localparam logic [8:0]  DaysLeapYr  = 9'd366;
   localparam logic [8:0]  DaysYr      = 9'd365;
   localparam logic [4:0]  DaysFebLeap = 5'd29;
   localparam logic [3:0]  MonthFeb    = 4'd1;
   localparam logic [3:0]  MonthApr    = 4'd3;
   localparam logic [3:0]  MonthOct    = 4'd9;
   localparam logic [3:0]  MonthDec    = 4'd11;

   localparam logic [4:0] MonthDays [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // Gregorian leap test for 1970 + yoff. Offsets 2 mod 4 are years divisible
   // by four; in range only 2100 and 2200 are century years that skip it.
   function automatic logic is_leap(input logic [7:0] yoff);
      return (yoff[1:0] == 2'b10) && (yoff != YoffY2100) && (yoff != YoffY2200);
   endfunction

   // Length of month m (0 is January)
   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      if (m == MonthFeb && leap) begin
         len = DaysFebLeap;
      end else if (m <= MonthDec) begin
         len = MonthDays[m];
      end else begin
         len = MonthDays[MonthDec];
      end
      return len;
   endfunction

endpackage

// ===== rtl/core/epoch_seconds_to_calendar.sv =====
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_unix_seconds
// rsp      out        rsp_valid/rsp_stall   second, minute, hour, weekday, year_offset,
//                                           month, day
// csr      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// One request passes the accepting idle state, four reciprocal divisions
// (seconds, minutes, hours, weekday), each a multiply step then a quotient
// and remainder step on a shared multiplier, one compare/subtract per year
// and per month plus a closing step for the year scan and for a month scan
// that stops short of December, and a step to load the output register.
// req_stall is high from acceptance until the result moves to the output
// register; that register holds it while rsp_stall is high, and the next
// request is taken meanwhile. Synchronous active-high reset: idle, no result,
// timezone +1, summertime on.
`include "epoch_seconds_to_calendar_defines.svh"

module epoch_seconds_to_calendar (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_unix_seconds,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [5:0]          rsp_second,
   output logic [5:0]          rsp_minute,
   output logic signed [6:0]   rsp_hour,
   output logic [2:0]          rsp_weekday,
   output logic [7:0]          rsp_year_offset,
   output logic [3:0]          rsp_month,
   output logic [4:0]          rsp_day,
   // configuration channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [4:0]          csr_wdata
);

   esc_pkg::esc_state_type state_ff, state_in;

   logic [esc_pkg::DivWidth-1:0]   work_ff, work_in;
   logic [2*esc_pkg::DivWidth-1:0] prod_ff, prod_in;
   logic                           half_ff, half_in;
   logic [5:0]                     sec_ff, sec_in;
   logic [5:0]                     min_ff, min_in;
   logic [4:0]                     hutc_ff, hutc_in;
   logic [15:0]                    days_ff, days_in;
   logic [2:0]                     wday_ff, wday_in;
   logic [7:0]                     year_ff, year_in;
   logic [3:0]                     mon_ff, mon_in;

   logic signed [4:0]            tz_ff;
   logic                         dst_ff;

   logic                         out_valid_ff, out_valid_in;
   logic [5:0]                   out_sec_ff, out_sec_in;
   logic [5:0]                   out_min_ff, out_min_in;
   logic signed [6:0]            out_hour_ff, out_hour_in;
   logic [2:0]                   out_wday_ff, out_wday_in;
   logic [7:0]                   out_year_ff, out_year_in;
   logic [3:0]                   out_mon_ff, out_mon_in;
   logic [4:0]                   out_day_ff, out_day_in;

   // Shared subtractor
   logic [esc_pkg::SubWidth-1:0] sub_a, sub_b, sub_diff;
   logic                         sub_borrow;

   // Shared reciprocal multiplier
   logic [esc_pkg::DivWidth-1:0]   recip;
   logic [2*esc_pkg::DivWidth-1:0] mul_out;
   logic [5:0]                     div_k;
   logic [5:0]                     qd_low;

   logic                         req_take, rsp_take, out_free, leap;
   logic [esc_pkg::DivWidth-1:0] quot;
   logic [5:0]                   rem_val;
   logic [15:0]                  wday_arg;
   logic                         dst_on;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = out_valid_ff && !rsp_stall;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign leap     = esc_pkg::is_leap(year_ff);

   // Reciprocal, divisor and quotient for the current division pass
   always_comb begin
      recip = esc_pkg::RecipSixty;
      div_k = esc_pkg::SecPerMin;
      quot  = esc_pkg::DivWidth'(prod_ff >> esc_pkg::ShiftSixty);
      unique case (state_ff)
         esc_pkg::ST_DIV_MIN: begin
            div_k = esc_pkg::MinPerHour;
         end
         esc_pkg::ST_DIV_HOUR: begin
            recip = esc_pkg::RecipDay;
            div_k = esc_pkg::HourPerDay;
            quot  = esc_pkg::DivWidth'(prod_ff >> esc_pkg::ShiftDay);
         end
         esc_pkg::ST_DIV_WDAY: begin
            recip = esc_pkg::RecipWeek;
            div_k = esc_pkg::DaysPerWk;
            quot  = esc_pkg::DivWidth'(prod_ff >> esc_pkg::ShiftWeek);
         end
         default: ;
      endcase
   end

   assign mul_out  = {{esc_pkg::DivWidth{1'b0}}, work_ff} * {{esc_pkg::DivWidth{1'b0}}, recip};
   // remainder < 64, so six low bits of quotient * divisor are enough
   assign qd_low   = quot[5:0] * div_k;
   assign rem_val  = sub_diff[5:0];
   assign wday_arg = quot[15:0] + esc_pkg::WdayBias;

   // Summertime applies to April through October
   assign dst_on = dst_ff && (mon_ff >= esc_pkg::MonthApr) && (mon_ff <= esc_pkg::MonthOct);

   // Operand select for the subtractor
   always_comb begin
      sub_a = esc_pkg::SubWidth'(work_ff[5:0]);
      sub_b = esc_pkg::SubWidth'(qd_low);
      unique case (state_ff)
         esc_pkg::ST_YEAR_SCAN: begin
            sub_a = esc_pkg::SubWidth'(days_ff);
            sub_b = esc_pkg::SubWidth'(leap ? esc_pkg::DaysLeapYr : esc_pkg::DaysYr);
         end
         esc_pkg::ST_MONTH_SCAN: begin
            sub_a = esc_pkg::SubWidth'(days_ff);
            sub_b = esc_pkg::SubWidth'(esc_pkg::month_len(mon_ff, leap));
         end
         default: ;
      endcase
      {sub_borrow, sub_diff} = {1'b0, sub_a} - {1'b0, sub_b};
   end

   // Sequencer: next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      prod_in      = prod_ff;
      half_in      = half_ff;
      sec_in       = sec_ff;
      min_in       = min_ff;
      hutc_in      = hutc_ff;
      days_in      = days_ff;
      wday_in      = wday_ff;
      year_in      = year_ff;
      mon_in       = mon_ff;
      out_valid_in = out_valid_ff && !rsp_take;
      out_sec_in   = out_sec_ff;
      out_min_in   = out_min_ff;
      out_hour_in  = out_hour_ff;
      out_wday_in  = out_wday_ff;
      out_year_in  = out_year_ff;
      out_mon_in   = out_mon_ff;
      out_day_in   = out_day_ff;

      unique case (state_ff)
         esc_pkg::ST_IDLE: begin
            if (req_valid) begin
               work_in  = req_unix_seconds;
               half_in  = 1'b0;
               state_in = esc_pkg::ST_DIV_SEC;
            end
         end
         esc_pkg::ST_DIV_SEC, esc_pkg::ST_DIV_MIN,
         esc_pkg::ST_DIV_HOUR, esc_pkg::ST_DIV_WDAY: begin
            // multiply into prod_ff first, then take quotient and remainder from it
            half_in = !half_ff;
            if (!half_ff) begin
               prod_in = mul_out;
            end else begin
               unique case (state_ff)
                  esc_pkg::ST_DIV_SEC: begin
                     sec_in   = rem_val;
                     work_in  = quot;
                     state_in = esc_pkg::ST_DIV_MIN;
                  end
                  esc_pkg::ST_DIV_MIN: begin
                     min_in   = rem_val;
                     work_in  = quot;
                     state_in = esc_pkg::ST_DIV_HOUR;
                  end
                  esc_pkg::ST_DIV_HOUR: begin
                     hutc_in  = rem_val[4:0];
                     days_in  = quot[15:0];
                     work_in  = esc_pkg::DivWidth'(wday_arg);
                     state_in = esc_pkg::ST_DIV_WDAY;
                  end
                  default: begin
                     wday_in  = rem_val[2:0] + 3'd1;
                     year_in  = '0;
                     state_in = esc_pkg::ST_YEAR_SCAN;
                  end
               endcase
            end
         end
         esc_pkg::ST_YEAR_SCAN: begin
            // strip whole years while the remaining days cover one
            if (sub_borrow) begin
               mon_in   = '0;
               state_in = esc_pkg::ST_MONTH_SCAN;
            end else begin
               days_in = sub_diff[15:0];
               year_in = year_ff + 8'd1;
            end
         end
         esc_pkg::ST_MONTH_SCAN: begin
            if (sub_borrow) begin
               state_in = esc_pkg::ST_FINISH;
            end else begin
               days_in = sub_diff[15:0];
               if (mon_ff == esc_pkg::MonthDec) begin
                  state_in = esc_pkg::ST_FINISH;
               end else begin
                  mon_in = mon_ff + 4'd1;
               end
            end
         end
         esc_pkg::ST_FINISH: begin
            // move the result out once the output register is free
            if (out_free) begin
               out_valid_in = 1'b1;
               out_sec_in   = sec_ff;
               out_min_in   = min_ff;
               out_hour_in  = 7'(hutc_ff) + 7'(tz_ff) + 7'(dst_on);
               out_wday_in  = wday_ff;
               out_year_in  = year_ff;
               out_mon_in   = mon_ff + 4'd1;
               out_day_in   = days_ff[4:0] + 5'd1;
               state_in     = esc_pkg::ST_IDLE;
            end
         end
         default: state_in = esc_pkg::ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= esc_pkg::ST_IDLE;
         half_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         half_ff      <= half_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      prod_ff     <= prod_in;
      sec_ff      <= sec_in;
      min_ff      <= min_in;
      hutc_ff     <= hutc_in;
      days_ff     <= days_in;
      wday_ff     <= wday_in;
      year_ff     <= year_in;
      mon_ff      <= mon_in;
      out_sec_ff  <= out_sec_in;
      out_min_ff  <= out_min_in;
      out_hour_ff <= out_hour_in;
      out_wday_ff <= out_wday_in;
      out_year_ff <= out_year_in;
      out_mon_ff  <= out_mon_in;
      out_day_ff  <= out_day_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tz_ff  <= esc_pkg::TimezoneReset;
         dst_ff <= esc_pkg::SummertimeReset;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == esc_pkg::CsrTimezone) begin
            tz_ff <= csr_wdata;
         end else begin
            dst_ff <= csr_wdata[0];
         end
      end
   end

   assign csr_ready       = 1'b1;
   assign req_stall       = (state_ff != esc_pkg::ST_IDLE);
   assign rsp_valid       = out_valid_ff;
   assign rsp_second      = out_sec_ff;
   assign rsp_minute      = out_min_ff;
   assign rsp_hour        = out_hour_ff;
   assign rsp_weekday     = out_wday_ff;
   assign rsp_year_offset = out_year_ff;
   assign rsp_month       = out_mon_ff;
   assign rsp_day         = out_day_ff;

   // Checks
   `ESC_ASSERT_NEXT(a_req_starts_div, clock, reset, req_take,
      state_ff == esc_pkg::ST_DIV_SEC && !half_ff)
   `ESC_ASSERT_NEXT(a_finish_loads, clock, reset, state_ff == esc_pkg::ST_FINISH && out_free,
      out_valid_ff && state_ff == esc_pkg::ST_IDLE)
   `ESC_ASSERT_IMP(a_year_range, clock, reset, state_ff == esc_pkg::ST_MONTH_SCAN,
      year_ff <= 8'd136 && mon_ff <= esc_pkg::MonthDec)
   `ESC_ASSERT_IMP(a_result_range, clock, reset, out_valid_ff,
      out_mon_ff >= 4'd1 && out_mon_ff <= 4'd12 && out_day_ff >= 5'd1 && out_wday_ff != 3'd0)

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int IDLE_CYCLE_LIMIT  = 10000;  // cycles with no handshake at all
   localparam int DRAIN_CYCLES      = 300;
   localparam int RANDOM_PER_PHASE  = 220;
   localparam int ITEMS_PER_SETTING = 75;
   localparam int SECS_PER_DAY      = 86400;
   localparam int LAST_WHOLE_DAY    = 49709;  // last full day below 2^32 seconds
   localparam int LAST_FULL_YEAR    = 135;    // 2105, last full year in range
   localparam int EPOCH_YEAR        = 1970;
   localparam int FEBRUARY          = 1;
   localparam int DECEMBER          = 11;
   localparam int SUMMER_FIRST      = 4;
   localparam int SUMMER_LAST       = 10;
   localparam int MONTH_LEN [12]    = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   // 1970-04-01 23:00:00, summertime month at the top of the UTC day
   localparam logic [31:0] APRIL_LATE_1970 = 32'd7858800;

   typedef struct packed {
      logic [5:0]        second;
      logic [5:0]        minute;
      logic signed [6:0] hour;
      logic [2:0]        weekday;
      logic [7:0]        year_offset;
      logic [3:0]        month;
      logic [4:0]        day;
   } calendar_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [31:0]         req_unix_seconds;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [5:0]          rsp_second;
   logic [5:0]          rsp_minute;
   logic signed [6:0]   rsp_hour;
   logic [2:0]          rsp_weekday;
   logic [7:0]          rsp_year_offset;
   logic [3:0]          rsp_month;
   logic [4:0]          rsp_day;
   logic                csr_valid;
   logic                csr_ready;
   logic                csr_index;
   logic [4:0]          csr_wdata;

   // shadow copy of the configuration registers
   logic signed [4:0]   tz_cfg;
   logic                dst_cfg;

   calendar_type        pending_dates[$];
   int                  errors;
   int                  quiet_cycles;
   int                  send_idle_pct;
   int                  stall_pct;

   epoch_seconds_to_calendar DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_unix_seconds (req_unix_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_second       (rsp_second),
      .rsp_minute       (rsp_minute),
      .rsp_hour         (rsp_hour),
      .rsp_weekday      (rsp_weekday),
      .rsp_year_offset  (rsp_year_offset),
      .rsp_month        (rsp_month),
      .rsp_day          (rsp_day),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Gregorian calendar helpers, year given as offset from the epoch
   function automatic bit greg_leap(input int unsigned yoff);
      int unsigned yr;
      yr = EPOCH_YEAR + yoff;
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   function automatic int unsigned year_days(input int unsigned yoff);
      return greg_leap(yoff) ? 366 : 365;
   endfunction

   function automatic int unsigned month_days(input int unsigned mon, input int unsigned yoff);
      return (mon == FEBRUARY && greg_leap(yoff)) ? 29 : MONTH_LEN[mon];
   endfunction

   // Expected calendar fields for one epoch count under the given settings
   function automatic calendar_type calendar_of(input logic [31:0] epoch_secs,
                                                input logic signed [4:0] tz,
                                                input logic dst);
      calendar_type f;
      int unsigned  rest;
      int unsigned  days;
      int unsigned  yoff;
      int unsigned  mon;
      int           hr;
      rest = epoch_secs;
      f.second = 6'(rest % 60);
      rest = rest / 60;
      f.minute = 6'(rest % 60);
      rest = rest / 60;
      hr = int'(rest % 24);
      days = rest / 24;
      // day 0 was a Thursday, Sunday is 1
      f.weekday = 3'((days + 4) % 7 + 1);
      yoff = 0;
      while (days >= year_days(yoff)) begin
         days -= year_days(yoff);
         yoff++;
      end
      mon = 0;
      while (mon < DECEMBER && days >= month_days(mon, yoff)) begin
         days -= month_days(mon, yoff);
         mon++;
      end
      // offsets never carry into the date
      hr += tz;
      if (dst && mon + 1 >= SUMMER_FIRST && mon + 1 <= SUMMER_LAST) begin
         hr++;
      end
      f.hour = 7'(hr);
      f.year_offset = 8'(yoff);
      f.month = 4'(mon + 1);
      f.day = 5'(days + 1);
      return f;
   endfunction

   // Random epoch count: full range, day edges, month and year edges, range ends
   function automatic logic [31:0] pick_epoch();
      int unsigned yoff;
      int unsigned mon;
      int unsigned day_idx;
      logic [31:0] epoch;
      case ($urandom_range(4))
         0, 1: begin
            epoch = $urandom;
         end
         2: begin
            day_idx = $urandom_range(LAST_WHOLE_DAY);
            epoch = day_idx * SECS_PER_DAY;
            if ($urandom_range(1)) begin
               epoch += $urandom_range(59);
            end else begin
               epoch += SECS_PER_DAY - 1 - $urandom_range(59);
            end
         end
         3: begin
            // first or last day of a random month
            yoff = $urandom_range(LAST_FULL_YEAR);
            mon = $urandom_range(DECEMBER);
            day_idx = 0;
            for (int y = 0; y < yoff; y++) begin
               day_idx += year_days(y);
            end
            for (int m = 0; m < mon; m++) begin
               day_idx += month_days(m, yoff);
            end
            if ($urandom_range(1)) begin
               day_idx += month_days(mon, yoff) - 1;
            end
            epoch = day_idx * SECS_PER_DAY + $urandom_range(SECS_PER_DAY - 1);
         end
         default: begin
            if ($urandom_range(1)) begin
               epoch = $urandom_range(200000);
            end else begin
               epoch = 32'hFFFF_FFFF - $urandom_range(200000);
            end
         end
      endcase
      return epoch;
   endfunction

   task automatic check_field(input string name, input int want_val, input int got_val);
      if (want_val != got_val) begin
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want_val, got_val);
      end
   endtask

   // Shadow registers, expectations and result checks
   always @(posedge clock) begin
      calendar_type want;
      if (reset) begin
         tz_cfg <= esc_pkg::TimezoneReset;
         dst_cfg <= esc_pkg::SummertimeReset;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == esc_pkg::CsrTimezone) begin
               tz_cfg <= csr_wdata;
            end else begin
               dst_cfg <= csr_wdata[0];
            end
         end
         if (req_valid && !req_stall) begin
            pending_dates.push_back(calendar_of(req_unix_seconds, tz_cfg, dst_cfg));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_dates.size() == 0) begin
               errors++;
               $display("%0t: result with no request pending, expected none, got %0d-%0d-%0d",
                        $time, rsp_year_offset, rsp_month, rsp_day);
            end else begin
               want = pending_dates.pop_front();
               check_field("second", want.second, rsp_second);
               check_field("minute", want.minute, rsp_minute);
               check_field("hour", int'(want.hour), int'(rsp_hour));
               check_field("weekday", want.weekday, rsp_weekday);
               check_field("year_offset", want.year_offset, rsp_year_offset);
               check_field("month", want.month, rsp_month);
               check_field("day", want.day, rsp_day);
            end
         end
      end
   end

   // Receiver back-pressure
   always @(negedge clock) begin
      if (!reset) begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog: ends the run when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_CYCLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Send one request; valid stays high on return so back-to-back requests flow
   task automatic send_request(input logic [31:0] epoch_secs);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_unix_seconds <= epoch_secs;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_dates.size() != 0);
   endtask

   // Write both registers once the block has gone idle
   task automatic configure(input logic signed [4:0] tz, input logic [4:0] dst_word);
      wait_all_results();
      csr_valid <= 1'b1;
      csr_index <= esc_pkg::CsrTimezone;
      csr_wdata <= tz;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_index <= esc_pkg::CsrSummertime;
      csr_wdata <= dst_word;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Calendar edge cases under the reset settings
   task automatic test_reset_defaults();
      logic [31:0] edges[16] = '{
         32'd0,          32'd3599,       32'd3600,       32'd86399,
         32'd86400,      32'd7775999,    32'd7776000,    32'd26265599,
         32'd26265600,   32'd68169600,   32'd94694399,   32'd951782400,
         32'd4107456000, 32'd4107542400, 32'h7FFF_FFFF,  32'hFFFF_FFFF
      };
      send_idle_pct = 0;
      stall_pct = 0;
      foreach (edges[i]) begin
         send_request(edges[i]);
      end
   endtask

   // Offset extremes, both summertime settings
   task automatic test_timezone_extremes();
      logic signed [4:0] offsets[5] = '{5'b10000, 5'b10100, 5'b00000, 5'b01110, 5'b01111};
      foreach (offsets[k]) begin
         configure(offsets[k], 5'((k + 1) % 2));
         send_request(32'd0);
         send_request(APRIL_LATE_1970);
      end
   endtask

   // Random traffic over the idling modes, settings changed every so often
   task automatic test_random_traffic();
      int idle_mode[4] = '{0, 85, 0, 17};
      int stall_mode[4] = '{0, 0, 85, 17};
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_mode[phase];
         stall_pct = stall_mode[phase];
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n % ITEMS_PER_SETTING == 0) begin
               configure(5'($urandom_range(31)), 5'($urandom_range(31)));
            end
            send_request(pick_epoch());
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_unix_seconds = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = esc_pkg::CsrTimezone;
      csr_wdata = '0;
      errors = 0;
      quiet_cycles = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_timezone_extremes();
      test_random_traffic();

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (errors == 0 && pending_dates.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
